>>> design/spdl_pkg.sv
package spdl_pkg;

  localparam int MAX_DELAY = 2048;
  localparam int ADDR_W    = $clog2(MAX_DELAY);
  localparam int SAMPLE_W  = 16;
  localparam int COORD_W   = 16;
  localparam int SPM_W     = 16;
  localparam int FLEN_W    = 16;
  localparam int INDEX_W   = 17;
  localparam int CMP_W     = INDEX_W + 1;
  localparam logic [INDEX_W-1:0] INDEX_MAX = {INDEX_W{1'b1}};

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DX  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_DZ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DZ = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPM      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FLEN     = 3'd7;

  localparam logic [SPM_W-1:0]  SPM_RESET  = 16'd32914;
  localparam logic [FLEN_W-1:0] FLEN_RESET = 16'd512;

  typedef logic [ADDR_W-1:0] delay_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] dx;
    logic signed [COORD_W-1:0] dy;
    logic signed [COORD_W-1:0] dz;
  } offs_t;

  typedef struct packed {
    logic busy;
    logic done;
  } calc_stat_t;

endpackage

>>> design/spdl_in_if.sv
interface spdl_in_if;
  logic                                valid;
  logic                                ready;
  logic                                start_req;
  logic signed [spdl_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output start_req, output sample, input ready);
  modport sink   (input valid, input start_req, input sample, output ready);
endinterface

>>> design/spdl_out_if.sv
interface spdl_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [spdl_pkg::SAMPLE_W-1:0] left_sample;
  logic signed [spdl_pkg::SAMPLE_W-1:0] right_sample;
  logic                                left_in_frame;
  logic                                right_in_frame;

  modport source (output valid, output left_sample, output right_sample,
                  output left_in_frame, output right_in_frame, input ready);
  modport sink   (input valid, input left_sample, input right_sample,
                  input left_in_frame, input right_in_frame, output ready);
endinterface

>>> design/stereo_propagation_delay_line_unit.sv
// Stereo time-of-flight delay line. Each accepted request writes one source sample into a
// 2048-entry ring and yields one result holding the left and right taps, each delayed by
// floor(distance * samples_per_meter) samples (saturated at 2047) or zero before the delay
// has elapsed, plus per-channel in-frame flags. Ordinary requests stream at one per cycle
// (unless the output stalls) through a two-stage path (ring read, output register). A
// request with start_req set is first held while both delays are recomputed by one shared
// multiplier (five products per channel) and a one-bit-per-cycle square root (32 steps per
// channel). Ring entries are undefined until written; no clearing pass runs after reset.
// Configure only while idle: offsets and scale are sampled during the start recompute.
module stereo_propagation_delay_line_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [spdl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [spdl_pkg::CFG_W-1:0]        cfg_data_i,
  spdl_in_if.sink                           in_i,
  spdl_out_if.source                        out_o
);

  logic [spdl_pkg::COORD_W-1:0] left_dx_q, left_dy_q, left_dz_q;
  logic [spdl_pkg::COORD_W-1:0] right_dx_q, right_dy_q, right_dz_q;
  logic [spdl_pkg::SPM_W-1:0]   spm_q;
  logic [spdl_pkg::FLEN_W-1:0]  flen_q;

  spdl_pkg::offs_t      left_offs;
  spdl_pkg::offs_t      right_offs;
  spdl_pkg::calc_stat_t calc_stat;
  spdl_pkg::delay_t     left_delay;
  spdl_pkg::delay_t     right_delay;
  logic                 calc_start;
  logic                 fresh_q;

  logic [spdl_pkg::INDEX_W-1:0] idx_q;
  logic [spdl_pkg::INDEX_W-1:0] idx_eff;
  logic [spdl_pkg::ADDR_W-1:0]  wr_addr;
  logic [spdl_pkg::ADDR_W-1:0]  rd_addr_l;
  logic [spdl_pkg::ADDR_W-1:0]  rd_addr_r;
  logic [spdl_pkg::CMP_W-1:0]   idx_ext;
  logic [spdl_pkg::CMP_W-1:0]   lim_l;
  logic [spdl_pkg::CMP_W-1:0]   lim_r;

  logic accept;
  logic room;
  logic s1_move;

  logic                                 s1_valid_q;
  logic                                 s1_zero_l_q, s1_zero_r_q;
  logic                                 s1_byp_l_q, s1_byp_r_q;
  logic                                 s1_inf_l_q, s1_inf_r_q;
  logic signed [spdl_pkg::SAMPLE_W-1:0] s1_sample_q;
  logic signed [spdl_pkg::SAMPLE_W-1:0] rd_l;
  logic signed [spdl_pkg::SAMPLE_W-1:0] rd_r;
  logic signed [spdl_pkg::SAMPLE_W-1:0] tap_l;
  logic signed [spdl_pkg::SAMPLE_W-1:0] tap_r;

  logic                                 out_valid_q;
  logic signed [spdl_pkg::SAMPLE_W-1:0] out_left_q, out_right_q;
  logic                                 out_inf_l_q, out_inf_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_dx_q  <= '0;
      left_dy_q  <= '0;
      left_dz_q  <= '0;
      right_dx_q <= '0;
      right_dy_q <= '0;
      right_dz_q <= '0;
      spm_q      <= spdl_pkg::SPM_RESET;
      flen_q     <= spdl_pkg::FLEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        spdl_pkg::REG_LEFT_DX:  left_dx_q  <= cfg_data_i;
        spdl_pkg::REG_LEFT_DY:  left_dy_q  <= cfg_data_i;
        spdl_pkg::REG_LEFT_DZ:  left_dz_q  <= cfg_data_i;
        spdl_pkg::REG_RIGHT_DX: right_dx_q <= cfg_data_i;
        spdl_pkg::REG_RIGHT_DY: right_dy_q <= cfg_data_i;
        spdl_pkg::REG_RIGHT_DZ: right_dz_q <= cfg_data_i;
        spdl_pkg::REG_SPM:      spm_q      <= cfg_data_i;
        spdl_pkg::REG_FLEN:     flen_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign left_offs.dx  = left_dx_q;
  assign left_offs.dy  = left_dy_q;
  assign left_offs.dz  = left_dz_q;
  assign right_offs.dx = right_dx_q;
  assign right_offs.dy = right_dy_q;
  assign right_offs.dz = right_dz_q;

  // Hold a start request until both delays are fresh.
  assign calc_start = in_i.valid && in_i.start_req && !fresh_q && !calc_stat.busy;

  spdl_delay_calc u_calc (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (calc_start),
    .left_offs_i   (left_offs),
    .right_offs_i  (right_offs),
    .spm_i         (spm_q),
    .stat_o        (calc_stat),
    .left_delay_o  (left_delay),
    .right_delay_o (right_delay)
  );

  assign s1_move   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign room      = !s1_valid_q || s1_move;
  assign in_i.ready = room && !calc_stat.busy && (!in_i.start_req || fresh_q);
  assign accept    = in_i.valid && in_i.ready;

  assign idx_eff   = in_i.start_req ? '0 : idx_q;
  assign wr_addr   = idx_eff[spdl_pkg::ADDR_W-1:0];
  assign rd_addr_l = wr_addr - left_delay;
  assign rd_addr_r = wr_addr - right_delay;
  assign idx_ext   = spdl_pkg::CMP_W'(idx_eff);
  assign lim_l     = spdl_pkg::CMP_W'(flen_q) + spdl_pkg::CMP_W'(left_delay);
  assign lim_r     = spdl_pkg::CMP_W'(flen_q) + spdl_pkg::CMP_W'(right_delay);

  spdl_ring u_ring (
    .clk_i       (clk_i),
    .en_i        (accept),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (in_i.sample),
    .rd_addr_a_i (rd_addr_l),
    .rd_addr_b_i (rd_addr_r),
    .rd_data_a_o (rd_l),
    .rd_data_b_o (rd_r)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fresh_q     <= 1'b0;
      idx_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (calc_stat.done) begin
        fresh_q <= 1'b1;
      end else if (accept) begin
        fresh_q <= 1'b0;
      end
      if (accept) begin
        idx_q <= (idx_eff == spdl_pkg::INDEX_MAX) ? idx_eff : idx_eff + 1'b1;
      end
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_zero_l_q <= idx_eff < spdl_pkg::INDEX_W'(left_delay);
      s1_zero_r_q <= idx_eff < spdl_pkg::INDEX_W'(right_delay);
      s1_byp_l_q  <= left_delay == '0;
      s1_byp_r_q  <= right_delay == '0;
      s1_inf_l_q  <= idx_ext < lim_l;
      s1_inf_r_q  <= idx_ext < lim_r;
      s1_sample_q <= in_i.sample;
    end
  end

  // A zero delay taps the slot written by the same request: bypass the ring.
  assign tap_l = s1_zero_l_q ? '0 : (s1_byp_l_q ? s1_sample_q : rd_l);
  assign tap_r = s1_zero_r_q ? '0 : (s1_byp_r_q ? s1_sample_q : rd_r);

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_left_q  <= tap_l;
      out_right_q <= tap_r;
      out_inf_l_q <= s1_inf_l_q;
      out_inf_r_q <= s1_inf_r_q;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.left_sample    = out_left_q;
  assign out_o.right_sample   = out_right_q;
  assign out_o.left_in_frame  = out_inf_l_q;
  assign out_o.right_in_frame = out_inf_r_q;

endmodule

>>> design/spdl_delay_calc.sv
module spdl_delay_calc (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  spdl_pkg::offs_t                left_offs_i,
  input  spdl_pkg::offs_t                right_offs_i,
  input  logic [spdl_pkg::SPM_W-1:0]     spm_i,
  output spdl_pkg::calc_stat_t           stat_o,
  output spdl_pkg::delay_t               left_delay_o,
  output spdl_pkg::delay_t               right_delay_o
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ROOT} state_e;
  typedef enum logic [2:0] {SQ_DX, SQ_DY, SQ_DZ, SQ_SPM, MUL_N} step_e;

  state_e              state_q;
  step_e               step_q;
  logic                ch_q;
  logic                done_q;
  logic [31:0]         acc_q;
  logic [31:0]         spm2_q;
  logic [63:0]         n_q;
  logic [33:0]         rem_q;
  logic [31:0]         root_q;
  logic [4:0]          iter_q;
  spdl_pkg::delay_t    left_q;
  spdl_pkg::delay_t    right_q;

  spdl_pkg::offs_t     offs;
  logic signed [32:0]  op_a;
  logic signed [32:0]  op_b;
  logic signed [65:0]  prod;
  logic [35:0]         shifted;
  logic [35:0]         trial;
  logic                ge;
  logic [33:0]         rem_d;
  logic [31:0]         root_d;
  logic [15:0]         whole;
  spdl_pkg::delay_t    sat_delay;

  assign offs = ch_q ? right_offs_i : left_offs_i;

  always_comb begin
    case (step_q)
      SQ_DX: begin
        op_a = 33'(offs.dx);
        op_b = 33'(offs.dx);
      end
      SQ_DY: begin
        op_a = 33'(offs.dy);
        op_b = 33'(offs.dy);
      end
      SQ_DZ: begin
        op_a = 33'(offs.dz);
        op_b = 33'(offs.dz);
      end
      SQ_SPM: begin
        op_a = {17'd0, spm_i};
        op_b = {17'd0, spm_i};
      end
      MUL_N: begin
        op_a = {1'b0, acc_q};
        op_b = {1'b0, spm2_q};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod = op_a * op_b;

  assign shifted = {rem_q, n_q[63:62]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = shifted >= trial;
  assign rem_d   = ge ? 34'(shifted - trial) : shifted[33:0];
  assign root_d  = {root_q[30:0], ge};
  assign whole   = root_d[31:16];

  always_comb begin
    if ({1'b0, whole} > 17'(spdl_pkg::MAX_DELAY - 1)) begin
      sat_delay = spdl_pkg::delay_t'(spdl_pkg::MAX_DELAY - 1);
    end else begin
      sat_delay = spdl_pkg::delay_t'(whole);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= SQ_DX;
      ch_q    <= 1'b0;
      done_q  <= 1'b0;
      iter_q  <= '0;
      left_q  <= '0;
      right_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            ch_q    <= 1'b0;
            step_q  <= SQ_DX;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          case (step_q)
            SQ_DX:   step_q <= SQ_DY;
            SQ_DY:   step_q <= SQ_DZ;
            SQ_DZ:   step_q <= SQ_SPM;
            SQ_SPM:  step_q <= MUL_N;
            default: begin
              iter_q  <= 5'd31;
              state_q <= ST_ROOT;
            end
          endcase
        end
        ST_ROOT: begin
          if (iter_q == '0) begin
            if (ch_q) begin
              right_q <= sat_delay;
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end else begin
              left_q  <= sat_delay;
              ch_q    <= 1'b1;
              step_q  <= SQ_DX;
              state_q <= ST_MUL;
            end
          end else begin
            iter_q <= iter_q - 5'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE || (state_q == ST_ROOT && iter_q == '0)) begin
      acc_q <= '0;
    end else if (state_q == ST_MUL) begin
      case (step_q)
        SQ_DX, SQ_DY, SQ_DZ: acc_q <= acc_q + prod[31:0];
        SQ_SPM:              spm2_q <= prod[31:0];
        default: begin
          n_q    <= prod[63:0];
          rem_q  <= '0;
          root_q <= '0;
        end
      endcase
    end else if (state_q == ST_ROOT) begin
      n_q    <= {n_q[61:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign stat_o.busy   = (state_q != ST_IDLE) || done_q;
  assign stat_o.done   = done_q;
  assign left_delay_o  = left_q;
  assign right_delay_o = right_q;

endmodule

>>> design/spdl_ring.sv
module spdl_ring (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic [spdl_pkg::ADDR_W-1:0]          wr_addr_i,
  input  logic signed [spdl_pkg::SAMPLE_W-1:0] wr_data_i,
  input  logic [spdl_pkg::ADDR_W-1:0]          rd_addr_a_i,
  input  logic [spdl_pkg::ADDR_W-1:0]          rd_addr_b_i,
  output logic signed [spdl_pkg::SAMPLE_W-1:0] rd_data_a_o,
  output logic signed [spdl_pkg::SAMPLE_W-1:0] rd_data_b_o
);

  logic signed [spdl_pkg::SAMPLE_W-1:0] mem [spdl_pkg::MAX_DELAY];
  logic signed [spdl_pkg::SAMPLE_W-1:0] rd_a_q;
  logic signed [spdl_pkg::SAMPLE_W-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_a_q <= mem[rd_addr_a_i];
      rd_b_q <= mem[rd_addr_b_i];
    end
  end

  assign rd_data_a_o = rd_a_q;
  assign rd_data_b_o = rd_b_q;

endmodule
